/* hdl/lapedge_pkg.sv */
// Package: shared constants and types for the Laplacian RGB edge block.
`timescale 1ns / 1ps
`default_nettype none
package lapedge_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  localparam int CH_W      = 8;
  localparam int PIX_W     = 3 * CH_W;
  localparam int CFG_W     = 11;
  localparam int COORD_W   = 10;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int ROW_W     = $clog2(MAX_HEIGHT);
  localparam int NSUM_W    = CH_W + 3;
  localparam int DIFF_W    = NSUM_W + 1;

  // Width that holds any clamped size and the register value, plus one bit
  localparam int DIM_A     = ($clog2(MAX_WIDTH + 1) > $clog2(MAX_HEIGHT + 1)) ?
                             $clog2(MAX_WIDTH + 1) : $clog2(MAX_HEIGHT + 1);
  localparam int DIM_W     = ((DIM_A > CFG_W) ? DIM_A : CFG_W) + 1;

  localparam int NUM_REGS  = 2;
  localparam int APB_AW    = $clog2(NUM_REGS * 4);
  localparam int APB_DW    = 32;

  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = CFG_W'(640);
  localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = CFG_W'(480);

  localparam int CENTER_TAP = 4;

  typedef logic [8:0][CH_W-1:0] chan_win_t;

  typedef struct packed {
    logic [NSUM_W-1:0] nsum;
    logic [CH_W-1:0]   center;
  } lane_sum_t;

  typedef struct packed {
    logic               valid;
    logic [COL_W-1:0]   col;
    logic [ROW_W-1:0]   row;
    logic               done;
  } tag_t;

endpackage
`default_nettype wire

/* hdl/lapedge_if.sv */
// Interfaces: input pixel channel and output edge result channel.
`timescale 1ns / 1ps
`default_nettype none
interface lapedge_pix_if;
  import lapedge_pkg::*;
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] in_red;
  logic [CH_W-1:0] in_green;
  logic [CH_W-1:0] in_blue;
  modport source (output valid, output in_red, output in_green, output in_blue, input ready);
  modport sink   (input valid, input in_red, input in_green, input in_blue, output ready);
endinterface

interface lapedge_edge_if;
  import lapedge_pkg::*;
  logic               valid;
  logic               ready;
  logic [CH_W-1:0]    out_red;
  logic [CH_W-1:0]    out_green;
  logic [CH_W-1:0]    out_blue;
  logic [COORD_W-1:0] out_col;
  logic [COORD_W-1:0] out_row;
  logic               frame_done;
  modport source (output valid, output out_red, output out_green, output out_blue,
                  output out_col, output out_row, output frame_done, input ready);
  modport sink   (input valid, input out_red, input out_green, input out_blue,
                  input out_col, input out_row, input frame_done, output ready);
endinterface
`default_nettype wire

/* hdl/laplacian_edge_rgb_top.sv */
// Top level: raster counters, window, line buffer, three channel lanes, merge.
// Path of a pixel: stage 1 with line buffer read, stage 2 lane sums, output register.
// Throughput: one pixel per cycle while results are taken; a stage moves on when the
// next is free, so input is taken while a finished result waits if a stage is empty.
// Reset (sync, active high): counters, window, stage valids cleared, size 640x480.
// Line buffer RAM not cleared; user must read rows only after writes (unenforced).
`timescale 1ns / 1ps
`default_nettype none
module laplacian_edge_rgb_top (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [lapedge_pkg::APB_AW-1:0]    paddr,
  input  wire logic [lapedge_pkg::APB_DW-1:0]    pwdata,
  output logic      [lapedge_pkg::APB_DW-1:0]    prdata,
  output logic                                   pready,
  lapedge_pix_if.sink                            pix_in,
  lapedge_edge_if.source                         edge_out
);
  import lapedge_pkg::*;

  // configuration
  logic [CFG_W-1:0] frame_width;
  logic [CFG_W-1:0] frame_height;
  logic             reg_sel;
  logic [DIM_W-1:0] w_raw, h_raw, w_eff, h_eff;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FRAME_WIDTH_RST;
      frame_height <= FRAME_HEIGHT_RST;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_sel)
        REG_FRAME_WIDTH:  frame_width  <= pwdata[CFG_W-1:0];
        REG_FRAME_HEIGHT: frame_height <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_FRAME_WIDTH:  prdata = APB_DW'(frame_width);
      REG_FRAME_HEIGHT: prdata = APB_DW'(frame_height);
      default:          prdata = '0;
    endcase
  end

  assign w_raw = DIM_W'(frame_width);
  assign h_raw = DIM_W'(frame_height);

  always_comb begin
    if (w_raw < DIM_W'(3))              w_eff = DIM_W'(3);
    else if (w_raw > DIM_W'(MAX_WIDTH)) w_eff = DIM_W'(MAX_WIDTH);
    else                                w_eff = w_raw;
    if (h_raw < DIM_W'(3))               h_eff = DIM_W'(3);
    else if (h_raw > DIM_W'(MAX_HEIGHT)) h_eff = DIM_W'(MAX_HEIGHT);
    else                                 h_eff = h_raw;
  end

  // stage enables, back to front
  logic en_out, en2, en1, accept;
  logic s1_valid, s1_emit;
  tag_t s1_tag, s2_tag;

  assign en2    = !s2_tag.valid || en_out;
  assign en1    = !s1_valid || !s1_emit || en2;
  assign pix_in.ready = en1;
  assign accept = pix_in.valid && en1;

  // raster position of the next input
  logic [COL_W-1:0] col_cnt;
  logic [ROW_W-1:0] row_cnt;
  logic [DIM_W-1:0] c_ext, r_ext;
  logic             emit, done;

  assign c_ext = DIM_W'(col_cnt);
  assign r_ext = DIM_W'(row_cnt);
  assign emit  = (c_ext >= DIM_W'(2)) && (r_ext >= DIM_W'(2)) &&
                 (c_ext < w_eff) && (r_ext < h_eff);
  assign done  = (c_ext == w_eff - DIM_W'(1)) && (r_ext == h_eff - DIM_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt <= '0;
      row_cnt <= '0;
    end else if (accept) begin
      if (c_ext + DIM_W'(1) >= w_eff) begin
        col_cnt <= '0;
        row_cnt <= (r_ext + DIM_W'(1) >= h_eff) ? '0 : row_cnt + ROW_W'(1);
      end else begin
        col_cnt <= col_cnt + COL_W'(1);
      end
    end
  end

  // stage 1: pixel and line buffer read in flight
  logic [PIX_W-1:0]   s1_px;
  logic [COL_W-1:0]   s1_idx;
  logic [COL_W-1:0]   s1_col;
  logic [ROW_W-1:0]   s1_row;
  logic               s1_done;
  logic [2*PIX_W-1:0] rd_data;
  logic [PIX_W-1:0]   top_px, mid_px;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en1) begin
      s1_valid <= pix_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_px      <= {pix_in.in_red, pix_in.in_green, pix_in.in_blue};
      s1_idx     <= col_cnt;
      s1_emit    <= emit;
      s1_col     <= col_cnt - COL_W'(1);
      s1_row     <= row_cnt - ROW_W'(1);
      s1_done    <= done;
    end
  end

  assign s1_tag = '{valid: s1_valid && s1_emit, col: s1_col, row: s1_row, done: s1_done};
  assign top_px = rd_data[2*PIX_W-1:PIX_W];
  assign mid_px = rd_data[PIX_W-1:0];

  lapedge_linebuf u_linebuf (
    .clk     (clk),
    .rd_en   (en1),
    .rd_addr (col_cnt),
    .rd_data (rd_data),
    .wr_en   (en1 && s1_valid),
    .wr_addr (s1_idx),
    .wr_data ({mid_px, s1_px})
  );

  // window: two previous columns, top/mid/bottom each
  logic [PIX_W-1:0] win_col [6];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 6; k++) win_col[k] <= '0;
    end else if (en1 && s1_valid) begin
      win_col[0] <= win_col[3];
      win_col[1] <= win_col[4];
      win_col[2] <= win_col[5];
      win_col[3] <= top_px;
      win_col[4] <= mid_px;
      win_col[5] <= s1_px;
    end
  end

  logic [8:0][PIX_W-1:0] pix_win;
  chan_win_t             red_win, green_win, blue_win;

  assign pix_win = {s1_px, win_col[5], win_col[2], mid_px, win_col[4], win_col[1],
                    top_px, win_col[3], win_col[0]};

  always_comb begin
    for (int k = 0; k < 9; k++) begin
      red_win[k]   = pix_win[k][3*CH_W-1:2*CH_W];
      green_win[k] = pix_win[k][2*CH_W-1:CH_W];
      blue_win[k]  = pix_win[k][CH_W-1:0];
    end
  end

  // stage 2: lane sums
  lane_sum_t red_sum, green_sum, blue_sum;

  lapedge_lane u_lane_red   (.clk(clk), .en(en2), .win(red_win),   .sum(red_sum));
  lapedge_lane u_lane_green (.clk(clk), .en(en2), .win(green_win), .sum(green_sum));
  lapedge_lane u_lane_blue  (.clk(clk), .en(en2), .win(blue_win),  .sum(blue_sum));

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_tag.valid <= 1'b0;
    end else if (en2) begin
      s2_tag <= s1_tag;
    end
  end

  lapedge_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .tag       (s2_tag),
    .red_sum   (red_sum),
    .green_sum (green_sum),
    .blue_sum  (blue_sum),
    .en_out    (en_out),
    .edge_out  (edge_out)
  );

  // line buffer write and the next read never hit the same column
  a_rw_distinct: assert property (@(posedge clk) disable iff (rst)
    s1_valid && en1 |-> s1_idx != col_cnt)
    else $error("line buffer read and write at the same column");

  a_accept_s1: assert property (@(posedge clk) disable iff (rst)
    accept |=> s1_valid)
    else $error("accepted pixel did not reach stage 1");

  a_interior: assert property (@(posedge clk) disable iff (rst)
    s1_tag.valid |-> (s1_tag.col != '0) && (s1_tag.row != '0))
    else $error("result center on the border");

  a_s2_hold: assert property (@(posedge clk) disable iff (rst)
    s2_tag.valid && !en_out |=> s2_tag.valid && $stable(s2_tag.col))
    else $error("stage 2 result lost under stall");

endmodule
`default_nettype wire

/* hdl/lapedge_linebuf.sv */
// Line buffer: two image rows stored side by side in one synchronous RAM.
`timescale 1ns / 1ps
`default_nettype none
module lapedge_linebuf (
  input  wire logic                                 clk,
  input  wire logic                                 rd_en,
  input  wire logic [lapedge_pkg::COL_W-1:0]        rd_addr,
  output logic      [2*lapedge_pkg::PIX_W-1:0]      rd_data,
  input  wire logic                                 wr_en,
  input  wire logic [lapedge_pkg::COL_W-1:0]        wr_addr,
  input  wire logic [2*lapedge_pkg::PIX_W-1:0]      wr_data
);
  import lapedge_pkg::*;

  // {older row, newer row}
  logic [2*PIX_W-1:0] mem [MAX_WIDTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

/* hdl/lapedge_lane.sv */
// Channel lane: registers the neighbour sum and center of one 3x3 channel window.
`timescale 1ns / 1ps
`default_nettype none
module lapedge_lane (
  input  wire logic                   clk,
  input  wire logic                   en,
  input  wire lapedge_pkg::chan_win_t win,
  output lapedge_pkg::lane_sum_t      sum
);
  import lapedge_pkg::*;

  logic [NSUM_W-1:0] nsum;

  always_comb begin
    nsum = '0;
    for (int k = 0; k < 9; k++) begin
      if (k != CENTER_TAP) begin
        nsum = nsum + NSUM_W'(win[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum.nsum   <= nsum;
      sum.center <= win[CENTER_TAP];
    end
  end

endmodule
`default_nettype wire

/* hdl/lapedge_merge.sv */
// Merge stage: combines the three lanes, saturates and holds the output register.
`timescale 1ns / 1ps
`default_nettype none
module lapedge_merge (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire lapedge_pkg::tag_t      tag,
  input  wire lapedge_pkg::lane_sum_t red_sum,
  input  wire lapedge_pkg::lane_sum_t green_sum,
  input  wire lapedge_pkg::lane_sum_t blue_sum,
  output logic                        en_out,
  lapedge_edge_if.source              edge_out
);
  import lapedge_pkg::*;

  function automatic logic [CH_W-1:0] edge_sat(lane_sum_t s);
    logic [DIFF_W-1:0] diff;
    diff = {1'b0, s.center, 3'b000} - DIFF_W'(s.nsum);
    if (diff[DIFF_W-1]) begin
      return '0;
    end else if (diff[DIFF_W-2:CH_W] != '0) begin
      return '1;
    end else begin
      return diff[CH_W-1:0];
    end
  endfunction

  assign en_out = !edge_out.valid || edge_out.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      edge_out.valid <= 1'b0;
    end else if (en_out) begin
      edge_out.valid <= tag.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_out) begin
      edge_out.out_red    <= edge_sat(red_sum);
      edge_out.out_green  <= edge_sat(green_sum);
      edge_out.out_blue   <= edge_sat(blue_sum);
      edge_out.out_col    <= COORD_W'(tag.col);
      edge_out.out_row    <= COORD_W'(tag.row);
      edge_out.frame_done <= tag.done;
    end
  end

endmodule
`default_nettype wire

/* dv/testbench.sv */
// Testbench: directed and random pixel streams checked against a Laplacian edge predictor.
`timescale 1ns / 1ps
module testbench;
  import lapedge_pkg::*;

  localparam int MIN_DIM        = 3;
  localparam int DRAIN_CYCLES   = 8;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_SHOWN      = 10;
  localparam int GENERAL_ITEMS  = 950;
  localparam int CALM_ITEMS     = 150;
  localparam int WIDE_ITEMS     = 40;

  // directed: red/green bright or dark center on the opposite ring, blue near-flat; then reverse
  localparam logic [PIX_W-1:0] CENTER_HI = {8'd255, 8'd0, 8'd128};
  localparam logic [PIX_W-1:0] RING_LO   = {8'd0, 8'd255, 8'd128};
  localparam logic [PIX_W-1:0] CENTER_LO = {8'd0, 8'd255, 8'd17};
  localparam logic [PIX_W-1:0] RING_HI   = {8'd255, 8'd0, 8'd16};

  typedef struct packed {
    logic [CH_W-1:0]    red;
    logic [CH_W-1:0]    green;
    logic [CH_W-1:0]    blue;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic               done;
  } edge_res_t;

  class edge_scoreboard;
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    logic [PIX_W-1:0] older_row [MAX_WIDTH];
    logic [PIX_W-1:0] newer_row [MAX_WIDTH];
    logic [PIX_W-1:0] win_cols [6];
    logic [PIX_W-1:0] taps [9];
    int unsigned      col_pos;
    int unsigned      row_pos;
    edge_res_t        expected_edges [$];
    int               mismatches;

    function new();
      width_reg  = FRAME_WIDTH_RST;
      height_reg = FRAME_HEIGHT_RST;
      foreach (older_row[i]) older_row[i] = '0;
      foreach (newer_row[i]) newer_row[i] = '0;
      foreach (win_cols[i]) win_cols[i] = '0;
      col_pos    = 0;
      row_pos    = 0;
      mismatches = 0;
    endfunction

    function void set_reg(logic reg_sel, logic [APB_DW-1:0] data);
      if (reg_sel == REG_FRAME_WIDTH) width_reg = data[CFG_W-1:0];
      else height_reg = data[CFG_W-1:0];
    endfunction

    function int unsigned clamp_dim(logic [CFG_W-1:0] v, int unsigned hi);
      if (v < MIN_DIM) return MIN_DIM;
      if (v > hi) return hi;
      return int'(v);
    endfunction

    function int unsigned eff_width();
      return clamp_dim(width_reg, MAX_WIDTH);
    endfunction

    function int unsigned eff_height();
      return clamp_dim(height_reg, MAX_HEIGHT);
    endfunction

    // raster advance; a position past a shrunken size wraps on the next step
    function void advance_pos(inout int unsigned c, inout int unsigned r);
      if (c + 1 >= eff_width()) begin
        c = 0;
        r = (r + 1 >= eff_height()) ? 0 : r + 1;
      end else begin
        c = c + 1;
      end
    endfunction

    function int unsigned frame_remaining();
      int unsigned c;
      int unsigned r;
      int unsigned n;
      c = col_pos;
      r = row_pos;
      n = 0;
      do begin
        n++;
        advance_pos(c, r);
      end while (c != 0 || r != 0);
      return n;
    endfunction

    function logic [CH_W-1:0] lap_chan(int sh);
      int acc;
      int k;
      acc = 8 * int'((taps[CENTER_TAP] >> sh) & 24'hFF);
      for (k = 0; k < 9; k++) begin
        if (k != CENTER_TAP) acc -= int'((taps[k] >> sh) & 24'hFF);
      end
      if (acc < 0) acc = 0;
      if (acc > 255) acc = 255;
      return CH_W'(acc);
    endfunction

    function void note_pixel(logic [PIX_W-1:0] px);
      int unsigned      idx;
      logic [PIX_W-1:0] top;
      logic [PIX_W-1:0] mid;
      edge_res_t        res;
      idx = (col_pos < MAX_WIDTH) ? col_pos : MAX_WIDTH - 1;
      top = older_row[idx];
      mid = newer_row[idx];
      if (col_pos >= 2 && row_pos >= 2 && col_pos < eff_width() && row_pos < eff_height())
      begin
        taps = '{win_cols[0], win_cols[3], top,
                 win_cols[1], win_cols[4], mid,
                 win_cols[2], win_cols[5], px};
        res.red   = lap_chan(16);
        res.green = lap_chan(8);
        res.blue  = lap_chan(0);
        res.col   = COORD_W'(col_pos - 1);
        res.row   = COORD_W'(row_pos - 1);
        res.done  = (col_pos == eff_width() - 1) && (row_pos == eff_height() - 1);
        expected_edges.push_back(res);
      end
      win_cols[0] = win_cols[3];
      win_cols[1] = win_cols[4];
      win_cols[2] = win_cols[5];
      win_cols[3] = top;
      win_cols[4] = mid;
      win_cols[5] = px;
      older_row[idx] = mid;
      newer_row[idx] = px;
      advance_pos(col_pos, row_pos);
    endfunction

    function int pending();
      return expected_edges.size();
    endfunction

    function void check_result(edge_res_t got);
      edge_res_t want;
      if (expected_edges.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN)
          $display("ERROR: unexpected edge result at col %0d row %0d", got.col, got.row);
        return;
      end
      want = expected_edges.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN) begin
          $display("ERROR: expected rgb %0d/%0d/%0d col %0d row %0d done %0b",
                   want.red, want.green, want.blue, want.col, want.row, want.done);
          $display("       got      rgb %0d/%0d/%0d col %0d row %0d done %0b",
                   got.red, got.green, got.blue, got.col, got.row, got.done);
        end
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  lapedge_pix_if  pix_if ();
  lapedge_edge_if res_if ();

  edge_scoreboard sb;
  edge_res_t      seen;
  int             idle_pct;
  int             stall_left;
  int             quiet_cycles;
  int unsigned    general_items;
  int unsigned    n_pix;
  int unsigned    new_w;
  int unsigned    new_h;
  int             k;
  bit             at_frame_start;

  laplacian_edge_rgb_top u_dut (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .pix_in   (pix_if),
    .edge_out (res_if)
  );

  always #2 clk = ~clk;

  function automatic logic [PIX_W-1:0] random_pixel();
    logic [PIX_W-1:0] px;
    int i;
    px = PIX_W'($urandom);
    case ($urandom_range(0, 3))
      0: begin
        for (i = 0; i < 3; i++) px[i*CH_W +: CH_W] = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
      end
      1: begin
        // flat area with small noise
        for (i = 0; i < 3; i++) px[i*CH_W +: CH_W] = CH_W'($urandom_range(112, 143));
      end
      default: ;
    endcase
    return px;
  endfunction

  task automatic write_reg(input logic reg_sel, input int unsigned value);
    logic [APB_DW-1:0] data;
    data = APB_DW'(value);
    // bits above the register are don't-care
    if ($urandom_range(0, 3) == 0) data = data | (APB_DW'($urandom) << CFG_W);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_AW'({reg_sel, 2'b00});
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    sb.set_reg(reg_sel, data);
  endtask

  task automatic send_pixel(input logic [PIX_W-1:0] px);
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      pix_if.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    pix_if.valid    <= 1'b1;
    pix_if.in_red   <= px[2*CH_W +: CH_W];
    pix_if.in_green <= px[CH_W +: CH_W];
    pix_if.in_blue  <= px[0 +: CH_W];
    do @(posedge clk); while (!pix_if.ready);
    @(negedge clk);
  endtask

  // wait out every pending result, then let the pipeline drain with no input
  task automatic settle();
    pix_if.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  initial begin
    res_if.ready = 1'b1;
    stall_left   = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left--;
        res_if.ready <= 1'b0;
      end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
        stall_left = $urandom_range(0, 17);
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (pix_if.valid && pix_if.ready)
        sb.note_pixel({pix_if.in_red, pix_if.in_green, pix_if.in_blue});
      if (res_if.valid && res_if.ready) begin
        seen.red   = res_if.out_red;
        seen.green = res_if.out_green;
        seen.blue  = res_if.out_blue;
        seen.col   = res_if.out_col;
        seen.row   = res_if.out_row;
        seen.done  = res_if.frame_done;
        sb.check_result(seen);
      end
      if ((pix_if.valid && pix_if.ready) || (res_if.valid && res_if.ready) ||
          (psel && penable && pready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("laplacian_edge_rgb_top test failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    sb              = new();
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    pix_if.valid    = 1'b0;
    pix_if.in_red   = '0;
    pix_if.in_green = '0;
    pix_if.in_blue  = '0;
    idle_pct        = 0;
    quiet_cycles    = 0;
    general_items   = 0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // smallest frame via clamped sizes; saturation high, low and mid
    idle_pct = 15;
    write_reg(REG_FRAME_WIDTH, 0);
    write_reg(REG_FRAME_HEIGHT, 2);
    for (k = 0; k < 9; k++) send_pixel((k == CENTER_TAP) ? CENTER_HI : RING_LO);
    for (k = 0; k < 9; k++) send_pixel((k == CENTER_TAP) ? CENTER_LO : RING_HI);
    settle();

    // widest row (clamped from above), left mid-frame
    write_reg(REG_FRAME_WIDTH, 2047);
    write_reg(REG_FRAME_HEIGHT, MIN_DIM);
    repeat (WIDE_ITEMS) send_pixel(random_pixel());
    settle();
    // width shrinks below the current column: counter wraps
    write_reg(REG_FRAME_WIDTH, 7);
    repeat (sb.frame_remaining()) send_pixel(random_pixel());
    settle();

    // tallest frame, then height shrinks below the current row
    write_reg(REG_FRAME_WIDTH, MIN_DIM);
    write_reg(REG_FRAME_HEIGHT, 1500);
    repeat (40 * MIN_DIM) send_pixel(random_pixel());
    settle();
    write_reg(REG_FRAME_HEIGHT, 0);
    repeat (sb.frame_remaining()) send_pixel(random_pixel());
    settle();

    while (general_items < GENERAL_ITEMS) begin
      at_frame_start = (sb.col_pos == 0) && (sb.row_pos == 0);
      case ($urandom_range(0, 3))
        0: idle_pct = 0;
        1: idle_pct = 5;
        2: idle_pct = 15;
        default: idle_pct = 30;
      endcase
      if (general_items + CALM_ITEMS >= GENERAL_ITEMS) idle_pct = 0;
      if ($urandom_range(0, 3) != 0) begin
        // width only grows at a frame start so no unwritten line entry is read
        if (!at_frame_start) begin
          new_w = $urandom_range(0, sb.eff_width());
        end else begin
          case ($urandom_range(0, 7))
            0: new_w = $urandom_range(0, MIN_DIM - 1);
            1: new_w = $urandom_range(13, 40);
            default: new_w = $urandom_range(MIN_DIM, 12);
          endcase
        end
        write_reg(REG_FRAME_WIDTH, new_w);
      end
      if ($urandom_range(0, 3) != 0) begin
        case ($urandom_range(0, 9))
          0: new_h = $urandom_range(0, MIN_DIM - 1);
          1: new_h = $urandom_range(MAX_HEIGHT + 1, 2047);
          default: new_h = $urandom_range(MIN_DIM, 10);
        endcase
        write_reg(REG_FRAME_HEIGHT, new_h);
      end
      n_pix = sb.frame_remaining();
      if (n_pix > 400 || $urandom_range(0, 1) == 0) n_pix = $urandom_range(1, 40);
      repeat (n_pix) send_pixel(random_pixel());
      general_items += n_pix;
      settle();
    end

    if (sb.mismatches == 0) $display("laplacian_edge_rgb_top test passed");
    else $display("laplacian_edge_rgb_top test failed");
    $finish;
  end

endmodule
